// File: sv/periodic_timer_bank_core_macros.svh
// ----------------------------------------------------------------------------
// periodic_timer_bank_core_macros
// Assertion macros used by the timer bank core.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_CORE_MACROS_SVH
`define PERIODIC_TIMER_BANK_CORE_MACROS_SVH

// condition holds in the same cycle
`define PTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and codes of the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_DEL  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [1:0] EV_ADD    = 2'd0;
    localparam logic [1:0] EV_DEL    = 2'd1;
    localparam logic [1:0] EV_EXPIRE = 2'd2;
    localparam logic [1:0] EV_DONE   = 2'd3;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam logic [4:0] MAX_ACTIVE_RESET = 5'd16;

    typedef struct packed {
        logic shift;
        logic clear;
        logic walk_en;
        logic add_mode;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// File: sv/ptb_cell.sv
// ----------------------------------------------------------------------------
// ptb_cell
// One timer slot: valid flag, interval and elapsed count. A walk token is
// handed from cell to cell; the cell holding it claims itself on an add or
// ages itself on a tick.
// ----------------------------------------------------------------------------
module ptb_cell #(
    parameter int PERIOD_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ptb_pkg::t_cell_ctl     i_ctl,
    input  logic                   i_tok_in,
    input  logic                   i_del,
    input  logic [PERIOD_BITS-1:0] i_period,
    output logic                   o_tok,
    output logic                   o_valid,
    output logic                   o_hit
);
    import ptb_pkg::*;

    logic                   r_tok;
    logic                   r_valid;
    logic [PERIOD_BITS-1:0] r_period;
    logic [PERIOD_BITS-1:0] r_elapsed;
    logic [PERIOD_BITS-1:0] w_inc;
    logic                   w_expire;
    logic                   w_act;
    logic                   w_claim;
    logic                   w_age;

    assign w_inc    = r_elapsed + PERIOD_BITS'(1);
    assign w_expire = (w_inc >= r_period) || (w_inc == '0);
    assign w_act    = i_ctl.walk_en && r_tok;
    assign w_claim  = w_act && i_ctl.add_mode && !r_valid;
    assign w_age    = w_act && !i_ctl.add_mode && r_valid;

    assign o_tok   = r_tok;
    assign o_valid = r_valid;
    assign o_hit   = w_claim || (w_age && w_expire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_tok <= 1'b0;
            end else if (i_ctl.shift) begin
                r_tok <= i_tok_in;
            end
            if (i_del) begin
                r_valid <= 1'b0;
            end else if (w_claim) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_period  <= i_period;
            r_elapsed <= '0;
        end else if (w_age) begin
            r_elapsed <= w_expire ? '0 : w_inc;
        end
    end

endmodule

// File: sv/periodic_timer_bank_core.sv
// add refused up front and delete: result registered in the cycle after the transfer; undefined kind: no result
// add that is taken: the walk token stops at the first free slot
// tick: one slot per cycle along the cell chain while the result is not stalled, then tick done
// a stalled result stops the walk; one item is in work at a time
// synchronous active-low reset clears all slots, the active count and max_active to 16
// ----------------------------------------------------------------------------
// periodic_timer_bank_core
// Bank of periodic timers built as a chain of slot cells walked by a token.
// ----------------------------------------------------------------------------
module periodic_timer_bank_core #(
    parameter int TIMER_SLOTS = 16,
    parameter int PERIOD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_period,
    input  logic [3:0]  i_slot_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic        o_status,
    output logic [3:0]  o_result_id,
    output logic        o_last
);
    import ptb_pkg::*;

    `include "periodic_timer_bank_core_macros.svh"

    localparam int IW   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int ACW  = $clog2(TIMER_SLOTS + 1);
    localparam int CMPW = (ACW > 5) ? ACW : 5;

    t_state                 r_state, n_state;
    logic                   r_add_mode, n_add_mode;
    logic [IW-1:0]          r_idx, n_idx;
    logic [ACW-1:0]         r_active, n_active;
    logic [4:0]             r_max_active;
    logic [PERIOD_BITS-1:0] r_add_period;
    logic                   r_o_valid, n_o_valid;
    logic [1:0]             r_o_event, n_o_event;
    logic                   r_o_status, n_o_status;
    logic [3:0]             r_o_id, n_o_id;
    logic                   r_o_last, n_o_last;

    t_cell_ctl              w_ctl;
    logic                   w_tok_head;
    logic [TIMER_SLOTS-1:0] w_chain;
    logic [TIMER_SLOTS-1:0] w_tok;
    logic [TIMER_SLOTS-1:0] w_valid;
    logic [TIMER_SLOTS-1:0] w_hit;
    logic [TIMER_SLOTS-1:0] w_del;
    logic                   w_any_hit;
    logic                   w_step;
    logic                   w_accept;
    logic [PERIOD_BITS-1:0] w_period;
    logic [IW-1:0]          w_del_idx;
    logic                   w_del_range;
    logic                   w_del_ok;
    logic                   w_add_ok;

    assign w_step      = !r_o_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_step;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_period    = PERIOD_BITS'(i_period);
    assign w_del_idx   = IW'(i_slot_id);
    assign w_del_range = (int'(i_slot_id) < TIMER_SLOTS);
    assign w_del_ok    = w_del_range && w_valid[w_del_idx];
    assign w_add_ok    = (w_period != '0) && (CMPW'(r_active) < CMPW'(r_max_active));
    assign w_any_hit   = |w_hit;

    // token enters the head of the chain when a walk starts
    assign w_tok_head = w_accept &&
                        ((i_kind == KIND_TICK) || ((i_kind == KIND_ADD) && w_add_ok));
    assign w_chain[0] = w_tok_head;

    always_comb begin
        w_ctl.walk_en  = (r_state == S_WALK) && w_step;
        w_ctl.shift    = w_tok_head || w_ctl.walk_en;
        w_ctl.clear    = w_ctl.walk_en && r_add_mode && w_any_hit;
        w_ctl.add_mode = r_add_mode;
    end

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        assign w_del[g] = w_accept && (i_kind == KIND_DEL) && w_del_range &&
                          (w_del_idx == IW'(g));

        ptb_cell #(
            .PERIOD_BITS (PERIOD_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_tok_in (w_chain[g]),
            .i_del    (w_del[g]),
            .i_period (r_add_period),
            .o_tok    (w_tok[g]),
            .o_valid  (w_valid[g]),
            .o_hit    (w_hit[g])
        );

        if (g < TIMER_SLOTS - 1) begin : g_link
            assign w_chain[g+1] = w_tok[g];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_add_mode = r_add_mode;
        n_idx      = r_idx;
        n_active   = r_active;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_event  = r_o_event;
        n_o_status = r_o_status;
        n_o_id     = r_o_id;
        n_o_last   = r_o_last;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_ADD: begin
                            if (w_add_ok) begin
                                n_state    = S_WALK;
                                n_add_mode = 1'b1;
                                n_idx      = '0;
                            end else begin
                                n_o_valid  = 1'b1;
                                n_o_event  = EV_ADD;
                                n_o_status = ST_FAIL;
                                n_o_id     = '0;
                                n_o_last   = 1'b1;
                            end
                        end
                        KIND_DEL: begin
                            n_o_valid  = 1'b1;
                            n_o_event  = EV_DEL;
                            n_o_status = w_del_ok ? ST_OK : ST_FAIL;
                            n_o_id     = '0;
                            n_o_last   = 1'b1;
                            if (w_del_ok) begin
                                n_active = r_active - ACW'(1);
                            end
                        end
                        KIND_TICK: begin
                            n_state    = S_WALK;
                            n_add_mode = 1'b0;
                            n_idx      = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_step) begin
                    n_idx = r_idx + IW'(1);
                    if (w_any_hit) begin
                        n_o_valid  = 1'b1;
                        n_o_event  = r_add_mode ? EV_ADD : EV_EXPIRE;
                        n_o_status = ST_OK;
                        n_o_id     = 4'(r_idx);
                        n_o_last   = r_add_mode;
                    end
                    if (r_add_mode && w_any_hit) begin
                        n_state  = S_IDLE;
                        n_active = r_active + ACW'(1);
                    end else if (w_tok[TIMER_SLOTS-1]) begin
                        if (r_add_mode) begin
                            n_state    = S_IDLE;
                            n_o_valid  = 1'b1;
                            n_o_event  = EV_ADD;
                            n_o_status = ST_FAIL;
                            n_o_id     = '0;
                            n_o_last   = 1'b1;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (w_step) begin
                    n_state    = S_IDLE;
                    n_o_valid  = 1'b1;
                    n_o_event  = EV_DONE;
                    n_o_status = ST_OK;
                    n_o_id     = '0;
                    n_o_last   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_add_mode   <= 1'b0;
            r_idx        <= '0;
            r_active     <= '0;
            r_max_active <= MAX_ACTIVE_RESET;
            r_o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_add_mode <= n_add_mode;
            r_idx      <= n_idx;
            r_active   <= n_active;
            r_o_valid  <= n_o_valid;
            if (i_cfg_we) begin
                r_max_active <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_event  <= n_o_event;
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_last   <= n_o_last;
        if (w_accept) begin
            r_add_period <= w_period;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_event_res = r_o_event;
    assign o_status    = r_o_status;
    assign o_result_id = r_o_id;
    assign o_last      = r_o_last;

    `PTB_ASSERT_NOW(a_tok_single, i_clk, i_rst_n, 1'b1, $onehot0(w_tok),
        "more than one walk token in the chain")
    `PTB_ASSERT_NOW(a_hit_in_walk, i_clk, i_rst_n, w_any_hit, r_state == S_WALK,
        "slot reported outside a walk")
    `PTB_ASSERT_NOW(a_active_count, i_clk, i_rst_n, 1'b1,
        int'(r_active) == $countones(w_valid), "active count differs from valid slots")
    `PTB_ASSERT_NOW(a_tok_idle, i_clk, i_rst_n, r_state == S_IDLE, w_tok == '0,
        "walk token left in chain while idle")
    `PTB_ASSERT_NEXT(a_done_last, i_clk, i_rst_n, (r_state == S_DONE) && w_step,
        o_out_valid && o_last && (o_event_res == EV_DONE), "tick done not issued")

endmodule
